// ===== rtl/rtthp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtthp_pkg
// shared types, constants and helpers for the radiotap transmit header parser
// ----------------------------------------------------------------------------
package rtthp_pkg;

    // byte offset width and next-field offset width (one carry bit for overrun)
    localparam int unsigned OFS_W = 16;
    localparam int unsigned NFO_W = OFS_W + 1;

    // fixed radiotap header part: version, pad, length, first present word
    localparam logic [NFO_W-1:0] HDR_FIXED = NFO_W'(8);

    localparam logic [7:0] DEF_TRIES = 8'd11;
    localparam logic [7:0] DEF_POWER = 8'd60;
    localparam logic [7:0] DEF_RATE  = 8'd2;

    // flags field bit that marks a trailing fcs
    localparam int unsigned FCS_BIT = 4;

    // configuration register indexes
    localparam logic CFG_FIXED_RATE   = 1'b0;
    localparam logic CFG_FRAME_FORMAT = 1'b1;

    // radiotap present bits handled by the walk
    localparam logic [4:0] RT_TSFT         = 5'd0;
    localparam logic [4:0] RT_FLAGS        = 5'd1;
    localparam logic [4:0] RT_RATE         = 5'd2;
    localparam logic [4:0] RT_CHANNEL      = 5'd3;
    localparam logic [4:0] RT_FHSS         = 5'd4;
    localparam logic [4:0] RT_DBM_SIGNAL   = 5'd5;
    localparam logic [4:0] RT_DBM_NOISE    = 5'd6;
    localparam logic [4:0] RT_LOCK_QUALITY = 5'd7;
    localparam logic [4:0] RT_TX_ATTEN     = 5'd8;
    localparam logic [4:0] RT_DB_TX_ATTEN  = 5'd9;
    localparam logic [4:0] RT_DBM_TX_POWER = 5'd10;
    localparam logic [4:0] RT_ANTENNA      = 5'd11;
    localparam logic [4:0] RT_DB_SIGNAL    = 5'd12;
    localparam logic [4:0] RT_DB_NOISE     = 5'd13;
    localparam logic [4:0] RT_DATA_RETRIES = 5'd17;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_EXT,
        PH_WALK,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_last;
    } beat_t;

    // packed with tx_rate in the lowest bits
    typedef struct packed {
        logic        trim_fcs;
        logic [15:0] strip_length;
        logic [7:0]  tx_tries;
        logic [7:0]  tx_power;
        logic [7:0]  tx_rate;
    } result_t;

    // index of the lowest set bit, 0 when none is set
    function automatic logic [4:0] lowest_set(input logic [31:0] word);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (word[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/rtthp_in_stage.sv =====
// ----------------------------------------------------------------------------
// rtthp_in_stage
// input register for frame byte beats
// ----------------------------------------------------------------------------
module rtthp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  rtthp_pkg::beat_t  s_beat,
    output logic              s_ready,
    input  logic              adv,
    output logic              vld,
    output rtthp_pkg::beat_t  beat
);

    logic             vld_reg;
    rtthp_pkg::beat_t beat_reg;

    assign s_ready = !vld_reg || adv;
    assign vld     = vld_reg;
    assign beat    = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            beat_reg <= s_beat;
        end
    end

endmodule

// ===== rtl/rtthp_parse.sv =====
// ----------------------------------------------------------------------------
// rtthp_parse
// per-frame parse state and combinational byte step with result forming
// ----------------------------------------------------------------------------
module rtthp_parse (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  rtthp_pkg::beat_t   beat,
    input  logic [7:0]         fixed_rate,
    input  logic               frame_format,
    output rtthp_pkg::result_t res
);

    localparam int unsigned OFS_W = rtthp_pkg::OFS_W;
    localparam int unsigned NFO_W = rtthp_pkg::NFO_W;

    logic [OFS_W-1:0]  ofs_reg,   ofs_next;
    logic [15:0]       hl_reg,    hl_next;
    logic [31:0]       pres_reg,  pres_next;
    logic [NFO_W-1:0]  nfo_reg,   nfo_next;
    rtthp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]        rate_reg,  rate_next;
    logic [7:0]        power_reg, power_next;
    logic [7:0]        tries_reg, tries_next;
    logic [7:0]        flags_reg, flags_next;
    logic [7:0]        ffb_reg,   ffb_next;
    logic              hv_reg,    hv_next;
    logic              rseen_reg, rseen_next;
    logic              mode_reg,  mode_next;

    logic [7:0]       b;
    logic [4:0]       bit_sel;
    logic [15:0]      hl_cat;
    logic [NFO_W-1:0] pos_x;
    logic [NFO_W-1:0] up2;
    logic [NFO_W-1:0] up8;
    logic [NFO_W-1:0] flen;
    logic             ctl;
    logic             accept;
    logic [7:0]       o_rate;
    logic [7:0]       o_power;
    logic [7:0]       o_tries;
    logic [15:0]      o_strip;
    logic             o_trim;

    always_comb begin
        b       = beat.frame_byte;
        bit_sel = rtthp_pkg::lowest_set(pres_reg);
        hl_cat  = {b, hl_reg[7:0]};
        pos_x   = {1'b0, ofs_reg};
        up2     = (pos_x + NFO_W'(1)) & ~NFO_W'(1);
        up8     = (pos_x + NFO_W'(7)) & ~NFO_W'(7);

        ofs_next   = ofs_reg;
        hl_next    = hl_reg;
        pres_next  = pres_reg;
        nfo_next   = nfo_reg;
        phase_next = phase_reg;
        rate_next  = rate_reg;
        power_next = power_reg;
        tries_next = tries_reg;
        flags_next = flags_reg;
        ffb_next   = ffb_reg;
        hv_next    = hv_reg;
        rseen_next = rseen_reg;
        mode_next  = mode_reg;

        // first byte of a frame latches the mode, the version check and the frame byte
        if (ofs_reg == '0) begin
            mode_next = frame_format;
            hv_next   = (b == 8'h00);
            ffb_next  = b;
        end

        if (ofs_reg != '1) begin
            case (phase_reg)
                rtthp_pkg::PH_HDR: begin
                    if (ofs_reg == OFS_W'(1)) begin
                        if (mode_next) begin
                            ffb_next = b;
                        end
                    end else if (ofs_reg == OFS_W'(2)) begin
                        hl_next = {8'h00, b};
                    end else if (ofs_reg == OFS_W'(3)) begin
                        hl_next = hl_cat;
                        if (mode_next) begin
                            if (hl_cat == 16'd0) begin
                                ffb_next = 8'h00;
                            end else if (hl_cat == 16'd2) begin
                                ffb_next = 8'd2;
                            end else if (hl_cat == 16'd3) begin
                                ffb_next = b;
                            end
                        end
                    end else if (ofs_reg[OFS_W-1:2] == (OFS_W-2)'(1)) begin
                        pres_next[{ofs_reg[1:0], 3'b000} +: 8] = b;
                        if (ofs_reg[1:0] == 2'd3) begin
                            if (b[7]) begin
                                phase_next = rtthp_pkg::PH_EXT;
                            end else begin
                                phase_next = rtthp_pkg::PH_WALK;
                                nfo_next   = rtthp_pkg::HDR_FIXED;
                            end
                        end
                    end
                end
                rtthp_pkg::PH_EXT: begin
                    if (ofs_reg[1:0] == 2'd3 && !b[7]) begin
                        phase_next = rtthp_pkg::PH_WALK;
                        nfo_next   = pos_x + NFO_W'(1);
                    end
                end
                rtthp_pkg::PH_WALK: begin
                    if (pos_x == nfo_reg) begin
                        if (pres_reg == '0) begin
                            phase_next = rtthp_pkg::PH_DONE;
                        end else begin
                            pres_next = pres_reg & ~(32'd1 << bit_sel);
                            case (bit_sel)
                                rtthp_pkg::RT_FLAGS: begin
                                    flags_next = b;
                                    nfo_next   = pos_x + NFO_W'(1);
                                end
                                rtthp_pkg::RT_RATE: begin
                                    rate_next  = b;
                                    rseen_next = 1'b1;
                                    nfo_next   = pos_x + NFO_W'(1);
                                end
                                rtthp_pkg::RT_DBM_TX_POWER: begin
                                    power_next = b;
                                    nfo_next   = pos_x + NFO_W'(1);
                                end
                                rtthp_pkg::RT_DATA_RETRIES: begin
                                    tries_next = b + 8'd1;
                                    nfo_next   = pos_x + NFO_W'(1);
                                end
                                rtthp_pkg::RT_DBM_SIGNAL, rtthp_pkg::RT_DBM_NOISE,
                                rtthp_pkg::RT_ANTENNA, rtthp_pkg::RT_DB_SIGNAL,
                                rtthp_pkg::RT_DB_NOISE: begin
                                    nfo_next = pos_x + NFO_W'(1);
                                end
                                rtthp_pkg::RT_FHSS: begin
                                    nfo_next = pos_x + NFO_W'(2);
                                end
                                rtthp_pkg::RT_LOCK_QUALITY, rtthp_pkg::RT_TX_ATTEN,
                                rtthp_pkg::RT_DB_TX_ATTEN: begin
                                    nfo_next = up2 + NFO_W'(2);
                                end
                                rtthp_pkg::RT_CHANNEL: begin
                                    nfo_next = up2 + NFO_W'(4);
                                end
                                rtthp_pkg::RT_TSFT: begin
                                    nfo_next = up8 + NFO_W'(8);
                                end
                                default: begin
                                    // unknown field, stop walking
                                    pres_next = '0;
                                end
                            endcase
                            if (pres_next == '0) begin
                                phase_next = rtthp_pkg::PH_DONE;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            // frame control byte sits right after the radiotap header
            if (mode_next && ofs_reg >= OFS_W'(4) && ofs_reg == hl_next) begin
                ffb_next = b;
            end
            ofs_next = ofs_reg + OFS_W'(1);
        end

        // result for the frame ending with this byte
        flen    = pos_x + NFO_W'(1);
        o_rate  = (fixed_rate != 8'h00) ? fixed_rate : rtthp_pkg::DEF_RATE;
        o_power = rtthp_pkg::DEF_POWER;
        o_tries = rtthp_pkg::DEF_TRIES;
        o_strip = '0;
        o_trim  = 1'b0;
        ctl     = (ffb_next[3:2] == 2'b01);
        accept  = (flen >= rtthp_pkg::HDR_FIXED) && hv_next && (flen >= {1'b0, hl_next});
        if (!mode_next) begin
            if (ctl) begin
                o_tries = 8'd1;
            end
        end else if (accept) begin
            if (rseen_next) begin
                o_rate = rate_next;
            end
            o_power = power_next;
            o_tries = tries_next;
            o_strip = hl_next;
            o_trim  = flags_next[rtthp_pkg::FCS_BIT];
            if ({1'b0, hl_next} >= flen) begin
                ctl = 1'b0;
            end
            if (o_tries == 8'd0 && ctl) begin
                o_tries = 8'd1;
            end
        end
        if (o_rate == 8'd0) begin
            o_tries = rtthp_pkg::DEF_TRIES;
        end

        res.tx_rate      = o_rate;
        res.tx_power     = o_power;
        res.tx_tries     = o_tries;
        res.strip_length = o_strip;
        res.trim_fcs     = o_trim;

        // frame done, back to a clean per-frame state
        if (beat.is_last) begin
            ofs_next   = '0;
            hl_next    = '0;
            pres_next  = '0;
            nfo_next   = '0;
            phase_next = rtthp_pkg::PH_HDR;
            rate_next  = '0;
            power_next = rtthp_pkg::DEF_POWER;
            tries_next = rtthp_pkg::DEF_TRIES;
            flags_next = '0;
            ffb_next   = '0;
            hv_next    = 1'b0;
            rseen_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_reg   <= '0;
            hl_reg    <= '0;
            pres_reg  <= '0;
            nfo_reg   <= '0;
            phase_reg <= rtthp_pkg::PH_HDR;
            rate_reg  <= '0;
            power_reg <= rtthp_pkg::DEF_POWER;
            tries_reg <= rtthp_pkg::DEF_TRIES;
            flags_reg <= '0;
            ffb_reg   <= '0;
            hv_reg    <= 1'b0;
            rseen_reg <= 1'b0;
            mode_reg  <= 1'b1;
        end else if (step_en) begin
            ofs_reg   <= ofs_next;
            hl_reg    <= hl_next;
            pres_reg  <= pres_next;
            nfo_reg   <= nfo_next;
            phase_reg <= phase_next;
            rate_reg  <= rate_next;
            power_reg <= power_next;
            tries_reg <= tries_next;
            flags_reg <= flags_next;
            ffb_reg   <= ffb_next;
            hv_reg    <= hv_next;
            rseen_reg <= rseen_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

// ===== rtl/rtthp_out_stage.sv =====
// ----------------------------------------------------------------------------
// rtthp_out_stage
// result register toward the master side
// ----------------------------------------------------------------------------
module rtthp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  rtthp_pkg::result_t res_in,
    input  logic               m_ready,
    output logic               m_valid,
    output rtthp_pkg::result_t m_res,
    output logic               free
);

    logic               vld_reg;
    rtthp_pkg::result_t res_reg;

    assign free    = !vld_reg || m_ready;
    assign m_valid = vld_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (free) begin
            vld_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

// ===== rtl/radiotap_tx_header_parser.sv =====
// ----------------------------------------------------------------------------
// radiotap_tx_header_parser: one frame byte a beat, one result beat per frame
// path: a last byte is registered in the input stage, its result in the output stage
// throughput: one byte per cycle, unless a final byte waits on a busy result slot
// reset: synchronous active-low aresetn clears both stages and the parse state
// ----------------------------------------------------------------------------
module radiotap_tx_header_parser (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,

    // frame bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,   // is_last

    // per-frame transmit settings
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [7:0] tx_rate, [15:8] tx_power, [23:16] tx_tries,
                                   // [39:24] strip_length, [40] trim_fcs, [47:41] zero
);

    // configuration registers
    logic [7:0] fixed_rate_reg;
    logic       frame_format_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fixed_rate_reg   <= 8'h00;
            frame_format_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                rtthp_pkg::CFG_FIXED_RATE:   fixed_rate_reg   <= cfg_wdata;
                rtthp_pkg::CFG_FRAME_FORMAT: frame_format_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    rtthp_pkg::beat_t   s_beat;
    rtthp_pkg::beat_t   in_beat;
    rtthp_pkg::result_t step_res;
    rtthp_pkg::result_t out_res;
    logic               in_vld;
    logic               out_free;
    logic               adv;
    logic               load;

    assign s_beat.frame_byte = s_tdata;
    assign s_beat.is_last    = s_tlast;

    // a byte moves on unless it ends a frame and the result slot is still taken
    assign adv  = in_vld && (!in_beat.is_last || out_free);
    assign load = adv && in_beat.is_last;

    rtthp_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_beat  (s_beat),
        .s_ready (s_tready),
        .adv     (adv),
        .vld     (in_vld),
        .beat    (in_beat)
    );

    // header walk and result forming, state steps on every advancing byte
    rtthp_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (adv),
        .beat         (in_beat),
        .fixed_rate   (fixed_rate_reg),
        .frame_format (frame_format_reg),
        .res          (step_res)
    );

    rtthp_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .res_in  (step_res),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .m_res   (out_res),
        .free    (out_free)
    );

    assign m_tdata = {7'b0000000, out_res};

`ifndef NO_ASSERTIONS
    // a final byte loaded into the result slot shows up as a result beat
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_tvalid)
        else $error("result beat missing after final byte");

    // a final byte waiting on a full result slot is held, not dropped
    a_last_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld && in_beat.is_last && m_tvalid && !m_tready) |=> in_vld)
        else $error("final byte lost while result slot busy");

    // a zero rate always goes out with the default try count
    a_zero_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.tx_rate == 8'd0) |-> (out_res.tx_tries == rtthp_pkg::DEF_TRIES))
        else $error("zero rate without default tries");
`endif

endmodule
